// ===== rtl/queued_beep_sequencer_defines.svh =====
// Assertion macros for the beep sequencer.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef QUEUED_BEEP_SEQUENCER_DEFINES_SVH
`define QUEUED_BEEP_SEQUENCER_DEFINES_SVH

// Implication check, sampled on the rising clock and disabled during reset.
`define QBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant check that must hold at every sampled edge out of reset.
`define QBS_ASSERT_INV(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

// ===== rtl/qbs_pkg.sv =====
// Shared types and constants for the queued beep sequencer.
// No dependencies; used by the channel interfaces and the top level.
package qbs_pkg;

  localparam int unsigned TIME_IN_W   = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned QCOUNT_W    = 4;
  localparam logic [CFG_W-1:0] DEFAULT_OFF_RST = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_GAP  = 2'd2
  } phase_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_REQ  = 1'b1
  } op_e;

  typedef enum logic {
    CTL_WAIT = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_e;

endpackage

// ===== rtl/qbs_req_if.sv =====
// Input channel of the beep sequencer: ticks and beep requests.
// Depends on qbs_pkg for the field widths.
interface qbs_req_if;
  import qbs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [TIME_IN_W-1:0] on_time;
  logic [TIME_IN_W-1:0] off_time;
  logic                 use_default_off;

  modport source (output valid, op, on_time, off_time, use_default_off, input ready);
  modport sink   (input valid, op, on_time, off_time, use_default_off, output ready);
endinterface

// ===== rtl/qbs_res_if.sv =====
// Result channel of the beep sequencer: buzzer state after each item.
// Depends on qbs_pkg for the field widths.
interface qbs_res_if;
  import qbs_pkg::*;

  logic                valid;
  logic                ready;
  logic                buzz_en;
  logic [1:0]          phase;
  logic [QCOUNT_W-1:0] queue_count;
  logic                beep_dropped;

  modport source (output valid, buzz_en, phase, queue_count, beep_dropped, input ready);
  modport sink   (input valid, buzz_en, phase, queue_count, beep_dropped, output ready);
endinterface

// ===== rtl/queued_beep_sequencer.sv =====
// A result is registered as its item executes in the EXEC state that follows acceptance,
// or later while the previous result still waits to be taken.
// The sequencer takes no new item until the current one has executed; the queue
// memory is read as each item is accepted and used in the update of that item.
// Reset clears the phase, counters and pointers and loads the default gap
// of 100 ticks; the queue memory itself is not cleared.
`include "queued_beep_sequencer_defines.svh"

module queued_beep_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TIME_WIDTH  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  qbs_req_if.sink                   req,
  qbs_res_if.source                 res,
  input  logic                      cfg_we_i,
  input  logic [qbs_pkg::CFG_W-1:0] cfg_wdata_i
);
  import qbs_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW     = TIME_WIDTH;

  // Control state
  ctl_e               ctl_q, ctl_d;
  phase_e             phase_q, phase_d;
  logic [TW-1:0]      rem_q, rem_d;
  logic [TW-1:0]      gap_q, gap_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [CFG_W-1:0]   def_off_q;
  logic               res_valid_q;

  // Latched item and result payload
  logic               op_q;
  logic [TIME_IN_W-1:0] on_q;
  logic [TIME_IN_W-1:0] off_q;
  logic               usedef_q;
  logic               buzzer_q, buzzer_d;
  logic [1:0]         res_phase_q;
  logic [QCOUNT_W-1:0] count_q;
  logic               dropped_q, dropped_d;

  // Queue memory: each entry holds {gap, on time}.
  logic [2*TW-1:0]    mem [QUEUE_DEPTH];
  logic [2*TW-1:0]    rd_q;
  logic [2*TW-1:0]    wr_data;
  logic               mem_we;

  logic               accept;
  logic               out_free;
  logic               exec_go;
  logic [TW-1:0]      rem_dec;

  assign accept   = req.valid && req.ready;
  assign out_free = !res_valid_q || res.ready;

  // Next state of the item sequencer.
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CTL_WAIT: begin
        if (accept) ctl_d = CTL_EXEC;
      end
      CTL_EXEC: begin
        if (out_free) ctl_d = CTL_WAIT;
      end
      default: ctl_d = CTL_WAIT;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = 1'b0;
    exec_go   = 1'b0;
    case (ctl_q)
      CTL_WAIT: req.ready = 1'b1;
      CTL_EXEC: exec_go   = out_free;
      default: begin
        req.ready = 1'b0;
        exec_go   = 1'b0;
      end
    endcase
  end

  assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : '0;

  // Update of the beep state for one item, using the head entry read earlier.
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    gap_d     = gap_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    dropped_d = 1'b0;
    mem_we    = 1'b0;
    wr_data   = {TW'(usedef_q ? def_off_q : off_q), TW'(on_q)};
    if (exec_go) begin
      if (op_q == OP_TICK) begin
        case (phase_q)
          PH_IDLE: begin
            if (fill_q != '0) begin
              rem_d   = rd_q[TW-1:0];
              gap_d   = rd_q[2*TW-1:TW];
              head_d  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(head_q + 1'b1);
              fill_d  = FILL_W'(fill_q - 1'b1);
              phase_d = PH_ON;
            end
          end
          PH_ON: begin
            if (rem_dec == '0) begin
              phase_d = PH_GAP;
              rem_d   = gap_q;
            end else begin
              rem_d = rem_dec;
            end
          end
          PH_GAP: begin
            rem_d = rem_dec;
            if (rem_dec == '0) phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end else if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
        dropped_d = 1'b1;
      end else begin
        mem_we = 1'b1;
        tail_d = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(tail_q + 1'b1);
        fill_d = FILL_W'(fill_q + 1'b1);
      end
    end
  end

  assign buzzer_d = (phase_d == PH_ON);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CTL_WAIT;
      phase_q     <= PH_IDLE;
      rem_q       <= '0;
      gap_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      def_off_q   <= DEFAULT_OFF_RST;
      res_valid_q <= 1'b0;
    end else begin
      ctl_q   <= ctl_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
      gap_q   <= gap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      if (cfg_we_i) def_off_q <= cfg_wdata_i;
      if (exec_go) begin
        res_valid_q <= 1'b1;
      end else if (res.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req.op;
      on_q     <= req.on_time;
      off_q    <= req.off_time;
      usedef_q <= req.use_default_off;
    end
    if (exec_go) begin
      buzzer_q    <= buzzer_d;
      res_phase_q <= phase_d;
      count_q     <= QCOUNT_W'(fill_d);
      dropped_q   <= dropped_d;
    end
  end

  // Head entry is read as the item is accepted and held until the item is executed.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[tail_q] <= wr_data;
    if (accept) rd_q <= mem[head_q];
  end

  assign res.valid        = res_valid_q;
  assign res.buzz_en      = buzzer_q;
  assign res.phase        = res_phase_q;
  assign res.queue_count  = count_q;
  assign res.beep_dropped = dropped_q;

  `QBS_ASSERT_INV(a_fill_bound, fill_q <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")
  `QBS_ASSERT_IMP(a_empty_ptrs, fill_q == '0, head_q == tail_q, "empty queue with unequal pointers")
  `QBS_ASSERT_IMP(a_full_ptrs, fill_q == FILL_W'(QUEUE_DEPTH), head_q == tail_q,
                  "full queue with unequal pointers")
  `QBS_ASSERT_IMP(a_idle_rem, phase_q == PH_IDLE, rem_q == '0, "idle with ticks remaining")

endmodule

// ===== test/tb_queued_beep_sequencer.sv =====
// Self-checking testbench for queued_beep_sequencer: directed table, random items, then longest durations.
// Depends on qbs_pkg, qbs_req_if, qbs_res_if and the RTL top level; reads no files.
`timescale 1ns / 1ps

module tb_queued_beep_sequencer;
  import qbs_pkg::*;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned TIME_BITS  = 16;

  typedef struct packed {
    logic       buzzer;
    phase_e     phase;
    logic [3:0] count;
    logic       dropped;
  } beep_status_t;

  typedef struct packed {
    op_e          op;
    logic [15:0]  on_ticks;
    logic [15:0]  off_ticks;
    logic         use_def;
    logic         fixed;
    beep_status_t status;
  } beep_row_t;

  typedef struct packed {
    logic [15:0] on_ticks;
    logic [15:0] gap_ticks;
  } beep_entry_t;

  localparam beep_status_t ST_NONE = '{1'b0, PH_IDLE, 4'd0, 1'b0};

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  qbs_req_if beep_req ();
  qbs_res_if beep_res ();

  queued_beep_sequencer #(
    .QUEUE_DEPTH(FIFO_DEPTH),
    .TIME_WIDTH (TIME_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (beep_req),
    .res        (beep_res),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Sequencer state as the checker sees it.
  phase_e       seq_phase   = PH_IDLE;
  logic [15:0]  ticks_left  = '0;
  logic [15:0]  pending_gap = '0;
  logic [15:0]  gap_default = DEFAULT_OFF_RST;
  beep_entry_t  beep_fifo[$];

  beep_status_t awaited_status[$];
  int unsigned  mismatches = 0;

  // Tags of the item currently on the request channel.
  logic         row_fixed  = 1'b0;
  beep_status_t row_status = ST_NONE;

  bit           no_idle      = 1'b0;
  int unsigned  taken_count  = 0;
  int unsigned  seen_count   = 0;
  int unsigned  stall_left   = 0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(16, 0);
  endfunction

  function automatic logic [15:0] pick_duration();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 75) return 16'($urandom_range(4, 0));
    if (r < 95) return 16'($urandom_range(20, 0));
    return 16'($urandom_range(80, 0));
  endfunction

  // Applies one item to the checker's copy of the sequencer and returns the status after it.
  function automatic beep_status_t next_beep_status(input op_e op, input logic [15:0] on_t,
                                                    input logic [15:0] off_t, input logic use_def);
    beep_entry_t  head;
    beep_status_t st;
    st.dropped = 1'b0;
    if (op == OP_TICK) begin
      case (seq_phase)
        PH_IDLE: begin
          if (beep_fifo.size() != 0) begin
            head        = beep_fifo.pop_front();
            ticks_left  = head.on_ticks;
            pending_gap = head.gap_ticks;
            seq_phase   = PH_ON;
          end
        end
        PH_ON: begin
          if (ticks_left != 0) ticks_left--;
          if (ticks_left == 0) begin
            seq_phase  = PH_GAP;
            ticks_left = pending_gap;
          end
        end
        PH_GAP: begin
          if (ticks_left != 0) ticks_left--;
          if (ticks_left == 0) seq_phase = PH_IDLE;
        end
        default: seq_phase = PH_IDLE;
      endcase
    end else if (beep_fifo.size() >= FIFO_DEPTH) begin
      st.dropped = 1'b1;
    end else begin
      // The gap is fixed when the request is queued, not when it is popped.
      beep_fifo.push_back('{on_t, use_def ? gap_default : off_t});
    end
    st.buzzer = (seq_phase == PH_ON);
    st.phase  = seq_phase;
    st.count  = 4'(beep_fifo.size());
    return st;
  endfunction

  // Sampling side: checks results, predicts accepted items and tracks register writes.
  always @(posedge clk_i) begin : monitor
    beep_status_t want;
    beep_status_t model;
    if (rst_ni) begin
      if (beep_res.valid && beep_res.ready) begin
        taken_count++;
        if (awaited_status.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got buzzer %0d phase %0d count %0d dropped %0d",
                   $time, beep_res.buzz_en, beep_res.phase, beep_res.queue_count,
                   beep_res.beep_dropped);
        end else begin
          want = awaited_status.pop_front();
          if (beep_res.buzz_en !== want.buzzer || beep_res.phase !== want.phase ||
              beep_res.queue_count !== want.count || beep_res.beep_dropped !== want.dropped) begin
            mismatches++;
            $display("%0t: buzzer/phase/count/dropped expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     $time, want.buzzer, want.phase, want.count, want.dropped,
                     beep_res.buzz_en, beep_res.phase, beep_res.queue_count,
                     beep_res.beep_dropped);
          end
        end
      end
      if (beep_req.valid && beep_req.ready) begin
        model = next_beep_status(op_e'(beep_req.op), beep_req.on_time, beep_req.off_time,
                                 beep_req.use_default_off);
        awaited_status.push_back(row_fixed ? row_status : model);
      end
      if (cfg_we_i) gap_default = cfg_wdata_i;
    end
  end

  // Result side back-pressure: a stall only counts down while a result is on offer.
  always @(negedge clk_i) begin
    if (taken_count != seen_count) begin
      seen_count = taken_count;
      stall_left = draw_wait();
    end
    if (stall_left != 0) begin
      beep_res.ready <= 1'b0;
      if (beep_res.valid) stall_left--;
    end else begin
      beep_res.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was accepted.
  task automatic push_item(input beep_row_t row);
    int unsigned idle;
    idle = draw_wait();
    if (idle != 0) begin
      beep_req.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    beep_req.valid           <= 1'b1;
    beep_req.op              <= row.op;
    beep_req.on_time         <= row.on_ticks;
    beep_req.off_time        <= row.off_ticks;
    beep_req.use_default_off <= row.use_def;
    row_fixed                <= row.fixed;
    row_status               <= row.status;
    do @(posedge clk_i); while (!(beep_req.valid && beep_req.ready));
    @(negedge clk_i);
  endtask

  task automatic set_default_gap(input logic [15:0] value);
    beep_req.valid <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_items(input int unsigned count);
    beep_row_t   row;
    int unsigned left_in_seg;
    int unsigned req_pct;
    left_in_seg = 0;
    req_pct     = 30;
    for (int unsigned i = 0; i < count; i++) begin
      if (left_in_seg == 0) begin
        left_in_seg = $urandom_range(60, 15);
        case ($urandom_range(2, 0))
          0: req_pct = 10;
          1: req_pct = 35;
          default: req_pct = 70;
        endcase
        no_idle = ($urandom_range(3, 0) == 0);
      end
      left_in_seg--;
      // Ticks and dropped requests carry arbitrary field content.
      row.fixed     = 1'b0;
      row.status    = ST_NONE;
      row.on_ticks  = 16'($urandom);
      row.off_ticks = 16'($urandom);
      row.use_def   = 1'($urandom);
      if ($urandom_range(99, 0) < req_pct) begin
        row.op = OP_REQ;
        if (beep_fifo.size() < FIFO_DEPTH) begin
          row.on_ticks = pick_duration();
          row.use_def  = ($urandom_range(2, 0) == 0);
          if (!row.use_def) row.off_ticks = pick_duration();
        end
      end else begin
        row.op = OP_TICK;
      end
      push_item(row);
    end
    no_idle = 1'b0;
  endtask

  // Directed rows: short durations, the pop-tick rule, queue full with drops, field extremes.
  localparam beep_row_t DIRECTED_ROWS [25] = '{
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b1, '{1'b0, PH_IDLE, 4'd0, 1'b0}},
    '{OP_REQ,  16'd1,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd0,      16'd2,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'hFFFF,   16'hFFFF,   1'b1, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd3,      16'hFFFF,   1'b1, 1'b0, ST_NONE},
    '{OP_REQ,  16'd2,      16'd1,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd0,      16'd3,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd1,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd4,      16'd2,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd1,      16'd1,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd3,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'hFFFF,   16'hFFFF,   1'b0, 1'b1, '{1'b0, PH_IDLE, 4'd8, 1'b1}},
    '{OP_REQ,  16'd0,      16'd0,      1'b1, 1'b1, '{1'b0, PH_IDLE, 4'd8, 1'b1}},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'd1,      16'd1,      1'b0, 1'b0, ST_NONE},
    '{OP_REQ,  16'h5555,   16'hAAAA,   1'b0, 1'b1, '{1'b1, PH_ON, 4'd8, 1'b1}},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE},
    '{OP_TICK, 16'd0,      16'd0,      1'b0, 1'b0, ST_NONE}
  };

  initial begin : stimulus
    beep_row_t row;
    beep_req.valid           = 1'b0;
    beep_req.op              = OP_TICK;
    beep_req.on_time         = '0;
    beep_req.off_time        = '0;
    beep_req.use_default_off = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_wdata_i              = '0;
    rst_ni                   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) push_item(DIRECTED_ROWS[i]);

    // The first random pass runs on the reset default gap of 100 ticks.
    run_random_items(310);
    set_default_gap(16'd0);
    run_random_items(310);
    set_default_gap(16'd1);
    run_random_items(310);
    set_default_gap(16'($urandom_range(30, 2)));
    run_random_items(310);
    set_default_gap(16'd5);
    run_random_items(310);

    // Longest durations last, as they would hold the sequencer for the rest of the run.
    set_default_gap(16'hFFFF);
    row.fixed  = 1'b0;
    row.status = ST_NONE;
    for (int i = 0; i < 12; i++) begin
      row.op        = (i % 3 == 2) ? OP_TICK : OP_REQ;
      row.on_ticks  = 16'hFFFF;
      row.off_ticks = (i % 2 == 0) ? 16'hFFFF : 16'd0;
      row.use_def   = (i % 4 == 1);
      push_item(row);
    end
    beep_req.valid <= 1'b0;

    while (awaited_status.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(3_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== queued_beep_sequencer.f =====
+incdir+rtl
rtl/qbs_pkg.sv
rtl/qbs_req_if.sv
rtl/qbs_res_if.sv
rtl/queued_beep_sequencer.sv
test/tb_queued_beep_sequencer.sv
